>>> design/lfir_pkg.sv
// Shared types and constants of the line FIR block.
`timescale 1ns / 1ps
`default_nettype none

package lfir_pkg;

    localparam int SAMPLE_W   = 16;  // sample field width on the input channel
    localparam int COEF_W     = 18;  // Q2.16 coefficient width
    localparam int NUM_COEF   = 7;
    localparam int OUT_W      = 24;  // filtered field width
    localparam int CFG_ADDR_W = 3;
    localparam int HW_W       = 2;   // half_width register width
    localparam int TAP_IDX_W  = 3;   // enough for any tap position up to seven taps

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_WIDTH = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_0     = 3'd1;

    localparam logic signed [COEF_W-1:0] COEF_RESET_0 = 18'sd65536;

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

endpackage

`default_nettype wire

>>> design/lfir_cell.sv
// One window cell: holds a sample, passes it down the row, multiplies by its tap weight.
`timescale 1ns / 1ps
`default_nettype none

module lfir_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int PW          = SAMPLE_BITS + lfir_pkg::COEF_W
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_adv,
    input  wire logic                              i_shift,
    input  wire logic                              i_clr,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_x_in,
    input  wire logic signed [lfir_pkg::COEF_W-1:0] i_coef,
    output logic signed [SAMPLE_BITS-1:0]          o_x,
    output logic signed [PW-1:0]                   o_prod
);

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [PW-1:0]          r_prod;
    logic signed [PW-1:0]          w_prod;

    assign w_prod = PW'(r_x) * PW'(i_coef);

    // product uses the window as it stood before this edge's shift
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= w_prod;
            if (i_shift) begin
                r_x <= i_clr ? '0 : i_x_in;
            end
        end
    end

    assign o_x    = r_x;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> design/lfir_sum.sv
// Registered adder tree over the cell products, then rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module lfir_sum #(
    parameter int N  = 7,
    parameter int PW = 34,
    parameter int F  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire lfir_pkg::t_tag                i_tag,
    input  wire logic signed [PW-1:0]          i_prod [N],
    output lfir_pkg::t_tag                     o_tag,
    output logic signed [lfir_pkg::OUT_W-1:0]  o_data
);

    localparam int NP    = (N + 1) / 2;
    localparam int AW    = PW + 1;
    localparam int TW    = AW + $clog2(NP);
    localparam int OW    = lfir_pkg::OUT_W;
    localparam int EXT_W = ((TW > F + OW) ? TW : F + OW) + 1;

    localparam logic signed [EXT_W-1:0] RND  = EXT_W'(1) << (F - 1);
    localparam logic signed [EXT_W-1:0] OMAX = EXT_W'((2 ** (OW - 1)) - 1);
    localparam logic signed [EXT_W-1:0] OMIN = -OMAX - EXT_W'(1);

    logic signed [AW-1:0]    r_pair [NP];
    logic signed [TW-1:0]    r_total;
    logic signed [OW-1:0]    r_out;
    lfir_pkg::t_tag          r_tag_a;
    lfir_pkg::t_tag          r_tag_b;
    lfir_pkg::t_tag          r_tag_c;

    logic signed [TW-1:0]    w_total;
    logic signed [EXT_W-1:0] w_rnd;
    logic signed [EXT_W-1:0] w_sh;
    logic signed [OW-1:0]    w_sat;

    genvar p;
    generate
        for (p = 0; p < NP; p++) begin : g_pair
            if (2 * p + 1 < N) begin : g_two
                always_ff @(posedge i_clk) begin
                    if (i_adv) begin
                        r_pair[p] <= AW'(i_prod[2*p]) + AW'(i_prod[2*p+1]);
                    end
                end
            end else begin : g_one
                always_ff @(posedge i_clk) begin
                    if (i_adv) begin
                        r_pair[p] <= AW'(i_prod[2*p]);
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        w_total = '0;
        for (int k = 0; k < NP; k++) begin
            w_total = w_total + TW'(r_pair[k]);
        end
    end

    // add half an LSB, floor, clamp to the output range
    always_comb begin
        w_rnd = EXT_W'(r_total) + RND;
        w_sh  = w_rnd >>> F;
        if (w_sh > OMAX) begin
            w_sat = OW'(OMAX);
        end else if (w_sh < OMIN) begin
            w_sat = OW'(OMIN);
        end else begin
            w_sat = w_sh[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_total <= w_total;
            r_out   <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_tag_c <= '0;
        end else if (i_adv) begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
            r_tag_c <= r_tag_b;
        end
    end

    assign o_tag  = r_tag_c;
    assign o_data = r_out;

endmodule

`default_nettype wire

>>> design/line_fir_zero_padded_top.sv
// Top level of the zero-padded line FIR: control, config registers, cell row, adder tree.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[15:0] sample, tlast line_end
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[23:0] filtered, tlast last_of_line
//  cfg       in   i_cfg_we                       i_cfg_addr index, i_cfg_data value
//
// One request per cycle unless a held result or a line-end flush stalls the input.
// A result's m_axis_tvalid follows its window's shift through the product, pair sum,
// total and round/saturate registers. After a tlast request the row shifts in d
// zeros (d = 0..3), s_axis_tready low; the next line's first sample clears the window.
// A result held by m_axis_tready low freezes the whole pipeline and drops s_axis_tready.
// Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module line_fir_zero_padded_top #(
    parameter int MAX_TAPS       = 7,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [15:0]                         s_axis_tdata,  // [15:0] sample
    input  wire logic                                s_axis_tlast,  // line_end
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [23:0]                              m_axis_tdata,  // [23:0] filtered
    output logic                                     m_axis_tlast,  // last_of_line
    input  wire logic                                i_cfg_we,
    input  wire logic [lfir_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [lfir_pkg::COEF_W-1:0]         i_cfg_data
);

    localparam int PW = SAMPLE_BITS + lfir_pkg::COEF_W;
    localparam logic [lfir_pkg::HW_W-1:0] D_LIM = lfir_pkg::HW_W'((MAX_TAPS - 1) / 2);
    localparam logic [lfir_pkg::TAP_IDX_W-1:0] TOP_IDX =
        lfir_pkg::TAP_IDX_W'(MAX_TAPS - 1);

    // configuration
    logic [lfir_pkg::HW_W-1:0]          r_half_width;
    logic signed [lfir_pkg::COEF_W-1:0] r_coef [lfir_pkg::NUM_COEF];

    // line control
    logic [lfir_pkg::HW_W-1:0] r_left;   // flush shifts still to do
    logic [lfir_pkg::HW_W-1:0] r_seen;   // samples of this line, saturating
    logic                      r_clr;    // window holds a finished line
    lfir_pkg::t_tag            r_tag0;
    lfir_pkg::t_tag            r_tag1;

    logic                      w_adv;
    logic                      w_accept;
    logic                      w_flush;
    logic                      w_shift;
    logic                      w_emit;
    logic                      w_last;
    logic [lfir_pkg::HW_W-1:0] w_d;
    logic [lfir_pkg::TAP_IDX_W-1:0] w_base;

    logic signed [SAMPLE_BITS-1:0]      w_sample;
    logic signed [SAMPLE_BITS-1:0]      w_top_in;
    logic signed [SAMPLE_BITS-1:0]      w_x    [MAX_TAPS];
    logic signed [PW-1:0]               w_prod [MAX_TAPS];
    logic signed [lfir_pkg::COEF_W-1:0] w_cell_coef [MAX_TAPS];

    lfir_pkg::t_tag                     w_out_tag;
    logic signed [lfir_pkg::OUT_W-1:0]  w_out_data;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= '0;
            for (int k = 0; k < lfir_pkg::NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
            r_coef[0] <= lfir_pkg::COEF_RESET_0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lfir_pkg::CFG_HALF_WIDTH: begin
                    r_half_width <= i_cfg_data[lfir_pkg::HW_W-1:0];
                end
                default: begin
                    r_coef[i_cfg_addr - lfir_pkg::CFG_COEF_0] <= i_cfg_data;
                end
            endcase
        end
    end

    assign w_d    = (r_half_width < D_LIM) ? r_half_width : D_LIM;
    assign w_base = TOP_IDX - {w_d, 1'b0};

    // tap weight per window position; positions left of the kernel weigh zero
    always_comb begin
        logic [lfir_pkg::TAP_IDX_W-1:0] pos;
        for (int j = 0; j < MAX_TAPS; j++) begin
            pos = lfir_pkg::TAP_IDX_W'(j);
            if (pos >= w_base) begin
                w_cell_coef[j] = r_coef[pos - w_base];
            end else begin
                w_cell_coef[j] = '0;
            end
        end
    end

    // ---------------- handshake and line control ----------------
    assign w_adv         = !w_out_tag.valid || m_axis_tready;
    assign s_axis_tready = w_adv && (r_left == '0);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_flush       = w_adv && (r_left != '0);
    assign w_shift       = w_accept || w_flush;
    assign w_emit        = w_shift && (r_seen >= w_d);
    assign w_last        = w_accept ? (s_axis_tlast && (w_d == '0)) : (r_left == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_seen <= '0;
            r_clr  <= 1'b1;
            r_tag0 <= '0;
            r_tag1 <= '0;
        end else if (w_adv) begin
            r_tag0 <= '{valid: w_emit, last: w_last};
            r_tag1 <= r_tag0;
            if (w_shift) begin
                r_clr  <= 1'b0;
                r_seen <= (r_seen == 2'd3) ? r_seen : r_seen + 2'd1;
            end
            if (w_accept && s_axis_tlast) begin
                if (w_d == '0) begin
                    r_clr  <= 1'b1;
                    r_seen <= '0;
                end else begin
                    r_left <= w_d;
                end
            end
            if (w_flush) begin
                r_left <= r_left - 2'd1;
                if (r_left == 2'd1) begin
                    r_clr  <= 1'b1;
                    r_seen <= '0;
                end
            end
        end
    end

    // ---------------- cell row ----------------
    generate
        if (SAMPLE_BITS <= lfir_pkg::SAMPLE_W) begin : g_samp_trunc
            assign w_sample = s_axis_tdata[SAMPLE_BITS-1:0];
        end else begin : g_samp_ext
            assign w_sample = SAMPLE_BITS'(s_axis_tdata);
        end
    endgenerate

    assign w_top_in = w_accept ? w_sample : '0;

    genvar j;
    generate
        for (j = 0; j < MAX_TAPS; j++) begin : g_cell
            if (j == MAX_TAPS - 1) begin : g_top
                lfir_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS),
                    .PW          (PW)
                ) u_cell (
                    .i_clk   (i_clk),
                    .i_adv   (w_adv),
                    .i_shift (w_shift),
                    .i_clr   (1'b0),
                    .i_x_in  (w_top_in),
                    .i_coef  (w_cell_coef[j]),
                    .o_x     (w_x[j]),
                    .o_prod  (w_prod[j])
                );
            end else begin : g_mid
                lfir_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS),
                    .PW          (PW)
                ) u_cell (
                    .i_clk   (i_clk),
                    .i_adv   (w_adv),
                    .i_shift (w_shift),
                    .i_clr   (r_clr),
                    .i_x_in  (w_x[j+1]),
                    .i_coef  (w_cell_coef[j]),
                    .o_x     (w_x[j]),
                    .o_prod  (w_prod[j])
                );
            end
        end
    endgenerate

    // ---------------- adder tree and output register ----------------
    lfir_sum #(
        .N  (MAX_TAPS),
        .PW (PW),
        .F  (COEF_FRAC_BITS)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_tag   (r_tag1),
        .i_prod  (w_prod),
        .o_tag   (w_out_tag),
        .o_data  (w_out_data)
    );

    assign m_axis_tvalid = w_out_tag.valid;
    assign m_axis_tlast  = w_out_tag.last;
    assign m_axis_tdata  = w_out_data;

    // ---------------- assertions ----------------
    a_end_no_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && s_axis_tlast && (w_d == '0) |=> r_clr && (r_seen == '0))
        else $error("line end without flush did not close the line");

    a_flush_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && s_axis_tlast && (w_d != '0) |=> (r_left == $past(w_d)))
        else $error("flush count not loaded with half width");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flush && (r_left == 2'd1) |=> r_clr && (r_left == '0) && (r_seen == '0))
        else $error("final flush step did not close the line");

endmodule

`default_nettype wire
